### rtl/mrpc_pkg.sv
// Shared types and constants for the monochrome row-to-page frame store.
package mrpc_pkg;

    // Pixels carried by one source byte, and the number of column banks.
    localparam int unsigned LANES  = 8;
    localparam int unsigned LANE_W = 3;

    // Command codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Per-beat control from the decoder to the banks and the read path.
    typedef struct packed {
        logic [LANES-1:0]  wr_en;    // lane i writes column byte_column*8+i
        logic [LANES-1:0]  wr_val;   // pixel value for lane i
        logic [LANE_W-1:0] wr_bit;   // bit of the page byte (row mod 8)
        logic              rd_en;    // a read beat was accepted
        logic              rd_ok;    // read address lies inside the frame
        logic [LANE_W-1:0] rd_lane;  // bank that holds the read column
    } t_req_ctl;

endpackage

### rtl/mrpc_decode.sv
// Command decoder: turns one accepted beat into bank addresses and lane controls.
module mrpc_decode #(
    parameter int unsigned WIDTH  = 128,
    parameter int unsigned HEIGHT = 64,
    parameter int unsigned ADDR_W = 7
) (
    input  logic              i_accept,
    input  logic              i_command,
    input  logic [5:0]        i_row,
    input  logic [3:0]        i_byte_column,
    input  logic [7:0]        i_data_byte,
    input  logic [6:0]        i_area_x_first,
    input  logic [6:0]        i_area_x_last,
    input  logic [6:0]        i_read_column,
    input  logic [2:0]        i_read_page,
    output logic [ADDR_W-1:0] o_wr_addr,
    output logic [ADDR_W-1:0] o_rd_addr,
    output mrpc_pkg::t_req_ctl o_ctl
);

    localparam int unsigned BANK_COLS = (WIDTH + 7) / 8;
    localparam int unsigned PAGES     = (HEIGHT + 7) / 8;

    logic [15:0] wr_addr_full;
    logic [15:0] rd_addr_full;
    logic        row_ok;
    logic        area_ok;
    logic [6:0]  lane_x [mrpc_pkg::LANES];

    assign wr_addr_full = 16'(i_row[5:3]) * 16'(BANK_COLS) + 16'(i_byte_column);
    assign rd_addr_full = 16'(i_read_page) * 16'(BANK_COLS) + 16'(i_read_column[6:3]);
    assign o_wr_addr    = wr_addr_full[ADDR_W-1:0];
    assign o_rd_addr    = rd_addr_full[ADDR_W-1:0];

    assign row_ok  = 16'(i_row) < 16'(HEIGHT);
    assign area_ok = i_area_x_first <= i_area_x_last;

    always_comb begin
        o_ctl = '0;
        for (int i = 0; i < int'(mrpc_pkg::LANES); i++) begin
            lane_x[i]       = {i_byte_column, 3'(i)};
            // Bit 7 of the source byte is the leftmost pixel, lane 0.
            o_ctl.wr_val[i] = i_data_byte[7-i];
            o_ctl.wr_en[i]  = i_accept && (i_command == mrpc_pkg::CMD_WRITE)
                              && row_ok && area_ok
                              && (lane_x[i] >= i_area_x_first)
                              && (lane_x[i] <= i_area_x_last)
                              && (16'(lane_x[i]) < 16'(WIDTH));
        end
        o_ctl.wr_bit  = i_row[2:0];
        o_ctl.rd_en   = i_accept && (i_command == mrpc_pkg::CMD_READ);
        o_ctl.rd_ok   = (16'(i_read_column) < 16'(WIDTH))
                        && (16'(i_read_page) < 16'(PAGES));
        o_ctl.rd_lane = i_read_column[2:0];
    end

endmodule

### rtl/mrpc_bank.sv
// One column bank of the frame store: bit-wide writes, whole-byte registered reads.
module mrpc_bank #(
    parameter int unsigned DEPTH  = 128,
    parameter int unsigned ADDR_W = 7
) (
    input  logic              i_clk,
    input  logic              i_clr,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [2:0]        i_wbit,
    input  logic              i_wval,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // A clearing write zeroes a whole byte; a normal write touches one row bit.
    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_mem[i_waddr] <= '0;
        end else if (i_we) begin
            r_mem[i_waddr][i_wbit] <= i_wval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/mono_row_to_page_converter.sv
// Top level of the monochrome row-to-page frame store.
// The frame store holds a WIDTH x HEIGHT one-bit image in panel page layout and
// takes one command beat per clock cycle whenever busy is low. A write beat
// updates up to eight pixels of one row in the same cycle, because the store
// is split into eight column banks (column mod 8) that each take one bit write
// per cycle. A read beat returns its page byte on o_page_byte with
// o_result_valid high for exactly one cycle, in the cycle after the beat was
// accepted; the receiver cannot stall, and a read issued right after a write
// sees the written data. After reset the block runs a clearing pass over the
// banks, one bank row per cycle, zeroing all ceil(HEIGHT/8) * ceil(WIDTH/8)
// bank rows (128 at the default 128 x 64 frame); busy stays high until done.
module mono_row_to_page_converter #(
    parameter int unsigned WIDTH  = 128,
    parameter int unsigned HEIGHT = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_command,
    input  logic [5:0] i_row,
    input  logic [3:0] i_byte_column,
    input  logic [7:0] i_data_byte,
    input  logic [6:0] i_area_x_first,
    input  logic [6:0] i_area_x_last,
    input  logic [6:0] i_read_column,
    input  logic [2:0] i_read_page,
    output logic       o_result_valid,
    output logic [7:0] o_page_byte
);

    // Each bank holds one byte per page for every eighth column.
    localparam int unsigned BANK_COLS = (WIDTH + 7) / 8;
    localparam int unsigned PAGES     = (HEIGHT + 7) / 8;
    localparam int unsigned DEPTH     = BANK_COLS * PAGES;
    localparam int unsigned ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    logic                  accept;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     bank_waddr;
    mrpc_pkg::t_req_ctl    ctl;
    logic [7:0]            bank_q [mrpc_pkg::LANES];

    // Clearing pass state.
    logic                  r_clearing;
    logic                  n_clearing;
    logic [ADDR_W-1:0]     r_clr_addr;
    logic [ADDR_W-1:0]     n_clr_addr;

    // Read result path.
    logic                  r_out_valid;
    logic                  r_rd_ok;
    logic [mrpc_pkg::LANE_W-1:0] r_rd_lane;

    assign busy   = r_clearing;
    assign accept = start && !r_clearing;

    mrpc_decode #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT),
        .ADDR_W (ADDR_W)
    ) u_decode (
        .i_accept       (accept),
        .i_command      (i_command),
        .i_row          (i_row),
        .i_byte_column  (i_byte_column),
        .i_data_byte    (i_data_byte),
        .i_area_x_first (i_area_x_first),
        .i_area_x_last  (i_area_x_last),
        .i_read_column  (i_read_column),
        .i_read_page    (i_read_page),
        .o_wr_addr      (wr_addr),
        .o_rd_addr      (rd_addr),
        .o_ctl          (ctl)
    );

    // While clearing, every bank writes zero at the sweep address.
    assign bank_waddr = r_clearing ? r_clr_addr : wr_addr;

    for (genvar g = 0; g < int'(mrpc_pkg::LANES); g++) begin : g_bank
        mrpc_bank #(
            .DEPTH  (DEPTH),
            .ADDR_W (ADDR_W)
        ) u_bank (
            .i_clk   (i_clk),
            .i_clr   (r_clearing),
            .i_we    (ctl.wr_en[g]),
            .i_waddr (bank_waddr),
            .i_wbit  (ctl.wr_bit),
            .i_wval  (ctl.wr_val[g]),
            .i_re    (ctl.rd_en),
            .i_raddr (rd_addr),
            .o_rdata (bank_q[g])
        );
    end

    always_comb begin
        n_clearing = r_clearing;
        n_clr_addr = r_clr_addr;
        if (r_clearing) begin
            if (r_clr_addr == LAST_ADDR) begin
                n_clearing = 1'b0;
            end else begin
                n_clr_addr = r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_clearing  <= n_clearing;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= ctl.rd_en;
        end
    end

    // The lane and range check of a read travel alongside the bank read.
    always_ff @(posedge i_clk) begin
        if (ctl.rd_en) begin
            r_rd_ok   <= ctl.rd_ok;
            r_rd_lane <= ctl.rd_lane;
        end
    end

    assign o_result_valid = r_out_valid;
    // A read outside the frame returns zero.
    assign o_page_byte    = r_rd_ok ? bank_q[r_rd_lane] : 8'h00;

endmodule
